// File: hdl/dual_sensor_triggered_pwm_duty_defines.svh
// Assertion macros for the checker file of this block.
`ifndef DUAL_SENSOR_TRIGGERED_PWM_DUTY_DEFINES_SVH
`define DUAL_SENSOR_TRIGGERED_PWM_DUTY_DEFINES_SVH

// Same-cycle implication, quiet while reset is applied.
`define DSTPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dstpd: same-cycle check failed");

// Next-cycle implication, quiet while reset is applied.
`define DSTPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dstpd: next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define DSTPD_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("dstpd: reset check failed");

`endif

// File: hdl/dstpd_pkg.sv
package dstpd_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int REG_BITS    = 10;
    localparam int CFG_IDX_BITS = 3;
    localparam int MODE_BITS   = 3;
    localparam int LOCK_BITS   = 2;

    // Calibration length in A/B pairs
    localparam int CAL_PAIRS = 5;
    localparam int CNT_BITS  = (CAL_PAIRS > 1) ? $clog2(CAL_PAIRS) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(CAL_PAIRS);

    // Divide by CAL_PAIRS as multiply by a rounded-up reciprocal; exact for any sum
    // below 2**SUM_BITS because the rounding error stays under 16.
    localparam int RECIP_SHIFT = SUM_BITS + 4;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((2 ** RECIP_SHIFT) + CAL_PAIRS - 1) / CAL_PAIRS);

    // Compare and clamp widths
    localparam int WIDE_BITS = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int THR_BITS  = WIDE_BITS + 1;
    localparam int DIFF_BITS = WIDE_BITS + 2;

    // Sequencer modes
    localparam logic [MODE_BITS-1:0] MODE_CAL_A  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_CAL_B  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_IDLE_A = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_IDLE_B = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_LOCK_A = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_LOCK_B = 3'd5;

    // Reported lock states
    localparam logic [LOCK_BITS-1:0] LM_CAL    = 2'd0;
    localparam logic [LOCK_BITS-1:0] LM_IDLE   = 2'd1;
    localparam logic [LOCK_BITS-1:0] LM_LOCK_A = 2'd2;
    localparam logic [LOCK_BITS-1:0] LM_LOCK_B = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_MARGIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_CEILING_A = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_CEILING_B = 3'd4;

    typedef struct packed {
        logic [REG_BITS-1:0] trigger_margin;
        logic [REG_BITS-1:0] sample_offset;
        logic [REG_BITS-1:0] duty_floor;
        logic [REG_BITS-1:0] duty_ceiling_a;
        logic [REG_BITS-1:0] duty_ceiling_b;
    } cfg_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [CNT_BITS-1:0]    cal_count;
        logic [SUM_BITS-1:0]    sum_a;
        logic [SUM_BITS-1:0]    sum_b;
        logic [SAMPLE_BITS-1:0] baseline_a;
        logic [SAMPLE_BITS-1:0] baseline_b;
        logic [SAMPLE_BITS-1:0] held_a_sample;
        logic [REG_BITS-1:0]    duty;
    } state_t;

    typedef struct packed {
        logic [REG_BITS-1:0]  duty;
        logic                 want_channel;
        logic [LOCK_BITS-1:0] lock_mode;
        logic                 sample_ignored;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        trigger_margin: REG_BITS'(3),
        sample_offset:  REG_BITS'(145),
        duty_floor:     REG_BITS'(375),
        duty_ceiling_a: REG_BITS'(500),
        duty_ceiling_b: REG_BITS'(417)
    };

    localparam state_t STATE_RESET = '{
        mode:          MODE_CAL_A,
        cal_count:     '0,
        sum_a:         '0,
        sum_b:         '0,
        baseline_a:    '0,
        baseline_b:    '0,
        held_a_sample: '0,
        duty:          REG_BITS'(375)
    };

    // Channel the sequencer waits for in a given mode
    function automatic logic expect_of(input logic [MODE_BITS-1:0] mode);
        return mode inside {MODE_CAL_B, MODE_IDLE_B, MODE_LOCK_B};
    endfunction

    // Lock state reported for a given mode
    function automatic logic [LOCK_BITS-1:0] lock_of(input logic [MODE_BITS-1:0] mode);
        logic [LOCK_BITS-1:0] lm;
        case (mode)
            MODE_CAL_A, MODE_CAL_B:   lm = LM_CAL;
            MODE_IDLE_A, MODE_IDLE_B: lm = LM_IDLE;
            MODE_LOCK_A:              lm = LM_LOCK_A;
            default:                  lm = LM_LOCK_B;
        endcase
        return lm;
    endfunction

endpackage

// File: hdl/dstpd_step.sv
module dstpd_step (
    input  dstpd_pkg::state_t                   state,
    input  dstpd_pkg::cfg_t                     cfg,
    input  logic [dstpd_pkg::SAMPLE_BITS-1:0]   sample_value,
    input  logic                                sample_channel,
    output dstpd_pkg::state_t                   state_next,
    output dstpd_pkg::result_t                  result
);

    // True when the sample exceeds baseline plus margin, formed without wrap
    function automatic logic above(
        input logic [dstpd_pkg::SAMPLE_BITS-1:0] sample,
        input logic [dstpd_pkg::SAMPLE_BITS-1:0] base,
        input logic [dstpd_pkg::REG_BITS-1:0]    margin
    );
        logic [dstpd_pkg::THR_BITS-1:0] thr;
        thr = dstpd_pkg::THR_BITS'(base) + dstpd_pkg::THR_BITS'(margin);
        return dstpd_pkg::THR_BITS'(sample) > thr;
    endfunction

    // Sample minus offset, raised to the floor first, then cut to the ceiling
    function automatic logic [dstpd_pkg::REG_BITS-1:0] clamp_duty(
        input logic [dstpd_pkg::SAMPLE_BITS-1:0] sample,
        input logic [dstpd_pkg::REG_BITS-1:0]    offset,
        input logic [dstpd_pkg::REG_BITS-1:0]    lower,
        input logic [dstpd_pkg::REG_BITS-1:0]    upper
    );
        logic signed [dstpd_pkg::DIFF_BITS-1:0] d;
        logic signed [dstpd_pkg::DIFF_BITS-1:0] lo;
        logic signed [dstpd_pkg::DIFF_BITS-1:0] hi;
        d  = $signed(dstpd_pkg::DIFF_BITS'(sample)) - $signed(dstpd_pkg::DIFF_BITS'(offset));
        lo = $signed(dstpd_pkg::DIFF_BITS'(lower));
        hi = $signed(dstpd_pkg::DIFF_BITS'(upper));
        if (d < lo) begin
            d = lo;
        end
        if (d > hi) begin
            d = hi;
        end
        return d[dstpd_pkg::REG_BITS-1:0];
    endfunction

    logic                              ignored;
    logic                              last_pair;
    logic [dstpd_pkg::SUM_BITS-1:0]    sum_add;
    logic [dstpd_pkg::PROD_BITS-1:0]   product;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] quotient;
    logic [dstpd_pkg::REG_BITS-1:0]    duty_a;
    logic [dstpd_pkg::REG_BITS-1:0]    duty_b;

    // Running sum of the channel in calibration and its mean over all pairs
    assign sum_add = ((state.mode == dstpd_pkg::MODE_CAL_A) ? state.sum_a : state.sum_b)
                   + dstpd_pkg::SUM_BITS'(sample_value);
    assign product  = dstpd_pkg::PROD_BITS'(sum_add) * dstpd_pkg::PROD_BITS'(dstpd_pkg::RECIP);
    assign quotient = product[dstpd_pkg::RECIP_SHIFT +: dstpd_pkg::SAMPLE_BITS];

    assign ignored   = (sample_channel != dstpd_pkg::expect_of(state.mode));
    assign last_pair = (state.cal_count == dstpd_pkg::CNT_BITS'(dstpd_pkg::CAL_PAIRS - 1));
    assign duty_a = clamp_duty(sample_value, cfg.sample_offset, cfg.duty_floor,
                               cfg.duty_ceiling_a);
    assign duty_b = clamp_duty(sample_value, cfg.sample_offset, cfg.duty_floor,
                               cfg.duty_ceiling_b);

    // Advance the sequencer by one request
    always_comb begin
        state_next = state;
        if (state.mode == dstpd_pkg::MODE_CAL_A || state.mode == dstpd_pkg::MODE_CAL_B) begin
            state_next.duty = cfg.duty_floor;
        end
        if (!ignored) begin
            case (state.mode)
                dstpd_pkg::MODE_CAL_A: begin
                    // A baseline is ready once the last A sample is in
                    if (last_pair) begin
                        state_next.baseline_a = quotient;
                        state_next.sum_a      = '0;
                    end else begin
                        state_next.sum_a = sum_add;
                    end
                    state_next.mode = dstpd_pkg::MODE_CAL_B;
                end
                dstpd_pkg::MODE_CAL_B: begin
                    if (last_pair) begin
                        state_next.baseline_b = quotient;
                        state_next.sum_b      = '0;
                        state_next.cal_count  = '0;
                        state_next.mode       = dstpd_pkg::MODE_IDLE_A;
                    end else begin
                        state_next.sum_b     = sum_add;
                        state_next.cal_count = state.cal_count + 1'b1;
                        state_next.mode      = dstpd_pkg::MODE_CAL_A;
                    end
                end
                dstpd_pkg::MODE_IDLE_A: begin
                    state_next.held_a_sample = sample_value;
                    state_next.mode          = dstpd_pkg::MODE_IDLE_B;
                end
                dstpd_pkg::MODE_IDLE_B: begin
                    // Judge the pair, A first
                    if (above(state.held_a_sample, state.baseline_a, cfg.trigger_margin)) begin
                        state_next.mode = dstpd_pkg::MODE_LOCK_A;
                    end else if (above(sample_value, state.baseline_b,
                                       cfg.trigger_margin)) begin
                        state_next.mode = dstpd_pkg::MODE_LOCK_B;
                    end else begin
                        state_next.duty = cfg.duty_floor;
                        state_next.mode = dstpd_pkg::MODE_IDLE_A;
                    end
                end
                dstpd_pkg::MODE_LOCK_A: begin
                    state_next.duty = duty_a;
                    if (!above(sample_value, state.baseline_a, cfg.trigger_margin)) begin
                        state_next.mode = dstpd_pkg::MODE_IDLE_A;
                    end
                end
                dstpd_pkg::MODE_LOCK_B: begin
                    state_next.duty = duty_b;
                    if (!above(sample_value, state.baseline_b, cfg.trigger_margin)) begin
                        state_next.mode = dstpd_pkg::MODE_IDLE_A;
                    end
                end
                default: begin
                    state_next.mode = dstpd_pkg::MODE_CAL_A;
                end
            endcase
        end
    end

    // Report the state left behind by this request
    always_comb begin
        result.duty           = state_next.duty;
        result.want_channel   = dstpd_pkg::expect_of(state_next.mode);
        result.lock_mode      = dstpd_pkg::lock_of(state_next.mode);
        result.sample_ignored = ignored;
    end

endmodule

// File: hdl/dual_sensor_triggered_pwm_duty.sv
// Dual-sensor triggered PWM duty: takes one channel-tagged ADC sample per clock while the
// result side is not stalled and returns one result per sample, through an input register,
// then a single pass of state update into the result register. The rate is one request per
// cycle while not stalled, set by that single-pass update of the mode, sums and duty.
// After reset it calibrates over dstpd_pkg::CAL_PAIRS alternating A/B pairs while duty sits
// at the floor, then judges each A/B pair and locks onto a channel whose sample rises
// above its baseline plus the margin. Samples from the channel not expected are reported
// as ignored. Write configuration only while no request is in flight; writes are always
// taken, and an index past the last register is dropped.
module dual_sensor_triggered_pwm_duty (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Sample requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dstpd_pkg::SAMPLE_BITS-1:0]    s_sample_value,
    input  logic                                 s_sample_channel,
    // Results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dstpd_pkg::REG_BITS-1:0]       m_duty,
    output logic                                 m_want_channel,
    output logic [dstpd_pkg::LOCK_BITS-1:0]      m_lock_mode,
    output logic                                 m_sample_ignored,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dstpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [dstpd_pkg::REG_BITS-1:0]       cfg_data
);

    logic                              in_valid_reg;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] in_value_reg;
    logic                              in_channel_reg;
    logic                              out_valid_reg;
    dstpd_pkg::result_t                out_result_reg;
    dstpd_pkg::result_t                result;
    dstpd_pkg::state_t                 state_reg;
    dstpd_pkg::state_t                 state_next;
    dstpd_pkg::cfg_t                   cfg_reg;
    logic                              advance;

    // Move the held request on whenever the result register is free or being emptied
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    dstpd_step u_step (
        .state          (state_reg),
        .cfg            (cfg_reg),
        .sample_value   (in_value_reg),
        .sample_channel (in_channel_reg),
        .state_next     (state_next),
        .result         (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg   <= s_sample_value;
            in_channel_reg <= s_sample_channel;
        end
    end

    // Sequencer state, updated once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dstpd_pkg::STATE_RESET;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_result_reg <= result;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= dstpd_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dstpd_pkg::CFG_TRIGGER_MARGIN: cfg_reg.trigger_margin <= cfg_data;
                dstpd_pkg::CFG_SAMPLE_OFFSET:  cfg_reg.sample_offset  <= cfg_data;
                dstpd_pkg::CFG_DUTY_FLOOR:     cfg_reg.duty_floor     <= cfg_data;
                dstpd_pkg::CFG_DUTY_CEILING_A: cfg_reg.duty_ceiling_a <= cfg_data;
                dstpd_pkg::CFG_DUTY_CEILING_B: cfg_reg.duty_ceiling_b <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_duty           = out_result_reg.duty;
    assign m_want_channel   = out_result_reg.want_channel;
    assign m_lock_mode      = out_result_reg.lock_mode;
    assign m_sample_ignored = out_result_reg.sample_ignored;

endmodule

// File: hdl/dstpd_checker.sv
`include "dual_sensor_triggered_pwm_duty_defines.svh"

module dstpd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [dstpd_pkg::REG_BITS-1:0]    m_duty,
    input logic                              m_want_channel,
    input logic [dstpd_pkg::LOCK_BITS-1:0]   m_lock_mode
);

    logic seen_run_reg;
    logic locked_shown;
    logic cal_shown;

    // Remember that calibration has been left behind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_run_reg <= 1'b0;
        end else if (m_valid && m_ready && m_lock_mode != dstpd_pkg::LM_CAL) begin
            seen_run_reg <= 1'b1;
        end
    end

    // Classify the result on offer
    assign locked_shown = m_valid && (m_lock_mode == dstpd_pkg::LM_LOCK_A
                                      || m_lock_mode == dstpd_pkg::LM_LOCK_B);
    assign cal_shown    = m_valid && (m_lock_mode == dstpd_pkg::LM_CAL);

    `DSTPD_ASSERT_NEXT_ALWAYS(a_reset_clears_result, !aresetn, !m_valid)
    `DSTPD_ASSERT_NEXT(a_stall_holds_result, m_valid && !m_ready, m_valid && $stable(m_duty))
    `DSTPD_ASSERT_IMPL(a_input_blocks_only_on_stall, !s_ready, m_valid && !m_ready)
    `DSTPD_ASSERT_IMPL(a_lock_wants_own_channel, locked_shown, m_want_channel == m_lock_mode[0])
    `DSTPD_ASSERT_IMPL(a_no_return_to_calibration, seen_run_reg, !cal_shown)

endmodule

bind dual_sensor_triggered_pwm_duty dstpd_checker u_dstpd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_duty         (m_duty),
    .m_want_channel (m_want_channel),
    .m_lock_mode    (m_lock_mode)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic CH_A = 1'b0;
    localparam logic CH_B = 1'b1;
    localparam int SAMPLE_MAX = (1 << dstpd_pkg::SAMPLE_BITS) - 1;
    localparam int DRAIN_CYCLES = 4;
    localparam int N_PHASES = 13;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam dstpd_pkg::result_t NO_RES = '0;

    // One row of the directed table; res is used only when typed is set
    typedef struct packed {
        logic [dstpd_pkg::SAMPLE_BITS-1:0] val;
        logic                              ch;
        logic                              typed;
        dstpd_pkg::result_t                res;
    } sample_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] s_sample_value = '0;
    logic s_sample_channel = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [dstpd_pkg::REG_BITS-1:0] m_duty;
    logic m_want_channel;
    logic [dstpd_pkg::LOCK_BITS-1:0] m_lock_mode;
    logic m_sample_ignored;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dstpd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [dstpd_pkg::REG_BITS-1:0] cfg_data = '0;

    // Shadow of the block's registers and sequencer
    dstpd_pkg::cfg_t cfg_shadow;
    logic [dstpd_pkg::MODE_BITS-1:0] seq_mode;
    int pair_count;
    int sum_a_acc;
    int sum_b_acc;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] base_a;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] base_b;
    logic [dstpd_pkg::SAMPLE_BITS-1:0] held_a;
    logic [dstpd_pkg::REG_BITS-1:0] duty_now;

    dstpd_pkg::result_t duty_expect_q[$];
    int fail_count = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    sample_row_t directed_rows [25];

    dual_sensor_triggered_pwm_duty dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .s_sample_channel (s_sample_channel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty           (m_duty),
        .m_want_channel   (m_want_channel),
        .m_lock_mode      (m_lock_mode),
        .m_sample_ignored (m_sample_ignored),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Channel the sequencer waits for in a mode
    function automatic logic wants_b(input logic [dstpd_pkg::MODE_BITS-1:0] m);
        return (m == dstpd_pkg::MODE_CAL_B) || (m == dstpd_pkg::MODE_IDLE_B)
            || (m == dstpd_pkg::MODE_LOCK_B);
    endfunction

    // Threshold is formed wide, so a large baseline plus margin never triggers
    function automatic logic crosses(input logic [dstpd_pkg::SAMPLE_BITS-1:0] v,
                                     input logic [dstpd_pkg::SAMPLE_BITS-1:0] base);
        return int'(v) > int'(base) + int'(cfg_shadow.trigger_margin);
    endfunction

    // Floor first, ceiling second: an inverted pair yields the ceiling
    function automatic logic [dstpd_pkg::REG_BITS-1:0] clamp_duty(
        input logic [dstpd_pkg::SAMPLE_BITS-1:0] v,
        input logic [dstpd_pkg::REG_BITS-1:0] ceiling);
        int d;
        d = int'(v) - int'(cfg_shadow.sample_offset);
        if (d < int'(cfg_shadow.duty_floor)) d = int'(cfg_shadow.duty_floor);
        if (d > int'(ceiling)) d = int'(ceiling);
        return dstpd_pkg::REG_BITS'(d);
    endfunction

    // Advance the shadow sequencer by one sample and form its result
    function automatic dstpd_pkg::result_t duty_step(
        input logic [dstpd_pkg::SAMPLE_BITS-1:0] v, input logic ch);
        dstpd_pkg::result_t r;
        logic skip;
        skip = (ch != wants_b(seq_mode));
        if (seq_mode == dstpd_pkg::MODE_CAL_A || seq_mode == dstpd_pkg::MODE_CAL_B)
            duty_now = cfg_shadow.duty_floor;
        if (!skip) begin
            case (seq_mode)
                dstpd_pkg::MODE_CAL_A: begin
                    sum_a_acc += int'(v);
                    seq_mode = dstpd_pkg::MODE_CAL_B;
                end
                dstpd_pkg::MODE_CAL_B: begin
                    sum_b_acc += int'(v);
                    pair_count++;
                    if (pair_count >= dstpd_pkg::CAL_PAIRS) begin
                        base_a = dstpd_pkg::SAMPLE_BITS'(sum_a_acc / dstpd_pkg::CAL_PAIRS);
                        base_b = dstpd_pkg::SAMPLE_BITS'(sum_b_acc / dstpd_pkg::CAL_PAIRS);
                        sum_a_acc = 0;
                        sum_b_acc = 0;
                        pair_count = 0;
                        seq_mode = dstpd_pkg::MODE_IDLE_A;
                    end else begin
                        seq_mode = dstpd_pkg::MODE_CAL_A;
                    end
                end
                dstpd_pkg::MODE_IDLE_A: begin
                    held_a = v;
                    seq_mode = dstpd_pkg::MODE_IDLE_B;
                end
                dstpd_pkg::MODE_IDLE_B: begin
                    if (crosses(held_a, base_a)) begin
                        seq_mode = dstpd_pkg::MODE_LOCK_A;
                    end else if (crosses(v, base_b)) begin
                        seq_mode = dstpd_pkg::MODE_LOCK_B;
                    end else begin
                        duty_now = cfg_shadow.duty_floor;
                        seq_mode = dstpd_pkg::MODE_IDLE_A;
                    end
                end
                dstpd_pkg::MODE_LOCK_A: begin
                    duty_now = clamp_duty(v, cfg_shadow.duty_ceiling_a);
                    if (!crosses(v, base_a)) seq_mode = dstpd_pkg::MODE_IDLE_A;
                end
                default: begin
                    duty_now = clamp_duty(v, cfg_shadow.duty_ceiling_b);
                    if (!crosses(v, base_b)) seq_mode = dstpd_pkg::MODE_IDLE_A;
                end
            endcase
        end
        r.duty = duty_now;
        r.want_channel = wants_b(seq_mode);
        case (seq_mode)
            dstpd_pkg::MODE_CAL_A, dstpd_pkg::MODE_CAL_B:   r.lock_mode = dstpd_pkg::LM_CAL;
            dstpd_pkg::MODE_IDLE_A, dstpd_pkg::MODE_IDLE_B: r.lock_mode = dstpd_pkg::LM_IDLE;
            dstpd_pkg::MODE_LOCK_A:                         r.lock_mode = dstpd_pkg::LM_LOCK_A;
            default:                                        r.lock_mode = dstpd_pkg::LM_LOCK_B;
        endcase
        r.sample_ignored = skip;
        return r;
    endfunction

    // Pick a sample value, often near the threshold of the given channel
    function automatic logic [dstpd_pkg::SAMPLE_BITS-1:0] pick_sample(input logic ch);
        int thr;
        int v;
        int roll;
        thr = int'(ch ? base_b : base_a) + int'(cfg_shadow.trigger_margin);
        roll = int'($urandom_range(99));
        if (roll < 40) v = thr - 4 + int'($urandom_range(8));
        else if (roll < 60) v = thr + 1 + int'($urandom_range(300));
        else if (roll < 70) v = (roll & 1) ? SAMPLE_MAX : 0;
        else v = int'($urandom_range(SAMPLE_MAX));
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return dstpd_pkg::SAMPLE_BITS'(v);
    endfunction

    // Offer one sample request, hold it until taken, then queue its expectation
    task automatic send_sample(input logic [dstpd_pkg::SAMPLE_BITS-1:0] v, input logic ch,
                               input logic typed, input dstpd_pkg::result_t typed_res);
        dstpd_pkg::result_t pred;
        s_valid <= 1'b1;
        s_sample_value <= v;
        s_sample_channel <= ch;
        do @(posedge aclk); while (!s_ready);
        pred = duty_step(v, ch);
        duty_expect_q.push_back(typed ? typed_res : pred);
        @(negedge aclk);
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic wait_drained();
        while (duty_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_reg(input logic [dstpd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [dstpd_pkg::REG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dstpd_pkg::CFG_TRIGGER_MARGIN: cfg_shadow.trigger_margin = data;
            dstpd_pkg::CFG_SAMPLE_OFFSET:  cfg_shadow.sample_offset = data;
            dstpd_pkg::CFG_DUTY_FLOOR:     cfg_shadow.duty_floor = data;
            dstpd_pkg::CFG_DUTY_CEILING_A: cfg_shadow.duty_ceiling_a = data;
            dstpd_pkg::CFG_DUTY_CEILING_B: cfg_shadow.duty_ceiling_b = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // Receiver: stall in short runs at a rate set per phase
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (int'($urandom_range(99)) < stall_pct) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        dstpd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_expect_q.size() == 0) begin
                $error("result with no request outstanding: duty %0d", m_duty);
                fail_count++;
            end else begin
                want = duty_expect_q.pop_front();
                check_field("duty", want.duty, m_duty);
                check_field("want_channel", want.want_channel, m_want_channel);
                check_field("lock_mode", want.lock_mode, m_lock_mode);
                check_field("sample_ignored", want.sample_ignored, m_sample_ignored);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        dstpd_pkg::cfg_t s;
        int gap;
        int burst_left;
        logic ch;
        logic hold;
        logic no_gaps;

        // Shadow state after reset
        cfg_shadow = dstpd_pkg::CFG_RESET;
        seq_mode = dstpd_pkg::MODE_CAL_A;
        pair_count = 0;
        sum_a_acc = 0;
        sum_b_acc = 0;
        base_a = '0;
        base_b = '0;
        held_a = '0;
        duty_now = dstpd_pkg::CFG_RESET.duty_floor;

        // Calibration gives baselines 404 (A) and 424 (B); thresholds 407 and 427
        directed_rows = '{
            '{10'd1023, CH_B, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_CAL, 1'b1}},
            '{10'd0,    CH_A, 1'b1, '{10'd375, CH_B, dstpd_pkg::LM_CAL, 1'b0}},
            '{10'd1023, CH_B, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_CAL, 1'b0}},
            '{10'd1023, CH_A, 1'b1, '{10'd375, CH_B, dstpd_pkg::LM_CAL, 1'b0}},
            '{10'd0,    CH_B, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_CAL, 1'b0}},
            '{10'd500,  CH_A, 1'b0, NO_RES},
            '{10'd100,  CH_B, 1'b0, NO_RES},
            '{10'd300,  CH_A, 1'b0, NO_RES},
            '{10'd400,  CH_B, 1'b0, NO_RES},
            '{10'd200,  CH_A, 1'b0, NO_RES},
            '{10'd600,  CH_B, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_IDLE, 1'b0}},
            // A just above threshold, then B quiet: lock on A, duty held
            '{10'd408,  CH_A, 1'b0, NO_RES},
            '{10'd0,    CH_B, 1'b0, NO_RES},
            '{10'd5,    CH_B, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_LOCK_A, 1'b1}},
            '{10'd1023, CH_A, 1'b1, '{10'd500, CH_A, dstpd_pkg::LM_LOCK_A, 1'b0}},
            '{10'd407,  CH_A, 1'b0, NO_RES},
            // lock on B, clamp at its ceiling, release at the threshold
            '{10'd0,    CH_A, 1'b0, NO_RES},
            '{10'd428,  CH_B, 1'b0, NO_RES},
            '{10'd1023, CH_B, 1'b1, '{10'd417, CH_B, dstpd_pkg::LM_LOCK_B, 1'b0}},
            '{10'd427,  CH_B, 1'b0, NO_RES},
            // both above: A wins
            '{10'd408,  CH_A, 1'b0, NO_RES},
            '{10'd1023, CH_B, 1'b0, NO_RES},
            '{10'd0,    CH_A, 1'b1, '{10'd375, CH_A, dstpd_pkg::LM_IDLE, 1'b0}},
            // idle pair without trigger
            '{10'd407,  CH_A, 1'b0, NO_RES},
            '{10'd427,  CH_B, 1'b0, NO_RES}
        };

        // Hold reset, then release it on a falling edge
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        stall_pct = 30;
        foreach (directed_rows[i])
            send_sample(directed_rows[i].val, directed_rows[i].ch,
                        directed_rows[i].typed, directed_rows[i].res);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            s_valid <= 1'b0;
            wait_drained();

            // Pick the register set: directed corner sets first, then random
            case (ph)
                0: s = '0;
                1: s = '1;
                2: begin
                    s = '0;
                    s.duty_ceiling_a = '1;
                    s.duty_ceiling_b = '1;
                end
                3: begin
                    s.trigger_margin = 10'd2;
                    s.sample_offset = 10'd100;
                    s.duty_floor = 10'd700;
                    s.duty_ceiling_a = 10'd200;
                    s.duty_ceiling_b = 10'd50;
                end
                4: begin
                    s = dstpd_pkg::CFG_RESET;
                    s.trigger_margin = '1;
                end
                5: s = dstpd_pkg::CFG_RESET;
                default: begin
                    s.trigger_margin = dstpd_pkg::REG_BITS'($urandom_range(0, 40));
                    s.sample_offset = dstpd_pkg::REG_BITS'($urandom_range(0, 400));
                    s.duty_floor = dstpd_pkg::REG_BITS'($urandom_range(0, 500));
                    s.duty_ceiling_a = dstpd_pkg::REG_BITS'($urandom_range(300, SAMPLE_MAX));
                    s.duty_ceiling_b = dstpd_pkg::REG_BITS'($urandom_range(0, SAMPLE_MAX));
                end
            endcase
            write_reg(dstpd_pkg::CFG_TRIGGER_MARGIN, s.trigger_margin);
            write_reg(dstpd_pkg::CFG_SAMPLE_OFFSET, s.sample_offset);
            write_reg(dstpd_pkg::CFG_DUTY_FLOOR, s.duty_floor);
            write_reg(dstpd_pkg::CFG_DUTY_CEILING_A, s.duty_ceiling_a);
            write_reg(dstpd_pkg::CFG_DUTY_CEILING_B, s.duty_ceiling_b);
            cfg_valid <= 1'b0;

            // Every fourth phase runs flat out on both sides
            no_gaps = (ph % 4 == 1);
            stall_pct = no_gaps ? 0 : int'($urandom_range(10, 60));

            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                hold = (n == ITEMS_PER_PHASE / 2);
                gap = 0;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = no_gaps ? 0 : int'($urandom_range(0, 6));
                end
                burst_left--;
                // Drop valid for the gap; mid-phase, hold off until all results are in
                if (gap != 0 || hold) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                    if (hold) wait_drained();
                end
                // Mostly the expected channel, now and then the other one
                ch = wants_b(seq_mode);
                if ($urandom_range(99) >= 88) ch = !ch;
                send_sample(pick_sample(ch), ch, 1'b0, NO_RES);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
